// ===== hdl/bppl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppl_pkg
// Shared widths, fixed-point constants, stage offsets and vector types of the
// Blinn-Phong point-light shader pipeline.
// ----------------------------------------------------------------------------
package bppl_pkg;

	// input packing
	localparam int COMPONENT_BITS_DEF = 16;
	localparam int WORD_W             = 48;
	localparam int CHAN_W             = 16;
	localparam int EXP_W              = 8;

	// fixed point
	localparam int Q_FRAC   = 14;
	localparam int ONE_Q14  = 16384;
	localparam int HALF_Q14 = 8192;
	localparam int UNIT_W   = 16;   // signed Q1.14 unit vector component
	localparam int DOT_W    = 15;   // unsigned 0..1.0 in Q.14
	localparam int IK_W     = 18;   // rounded intensity * coefficient

	// normalizer
	localparam int MAG_W    = 22;   // component magnitude after prescale
	localparam int NORM_BIT = 20;   // largest magnitude is lifted to this bit
	localparam int SH_W     = 5;
	localparam int LEN2_W   = 44;   // sum of squares
	localparam int ROOT_W   = 22;   // root bits, one per stage
	localparam int QUO_W    = 15;   // quotient bits, one per stage
	localparam int NUM_W    = 37;   // (mag << 14) + len/2

	localparam int NORM_LAT  = 5 + ROOT_W + 1 + QUO_W + 1;
	localparam int LIGHT_LAT = 5 + 2 * EXP_W;

	// global stage map
	localparam int STG_LE     = 1;
	localparam int STG_HS     = STG_LE + NORM_LAT;
	localparam int STG_H      = STG_HS + 1;
	localparam int STG_LIGHT  = STG_H + NORM_LAT;
	localparam int PIPE_DEPTH = STG_LIGHT + LIGHT_LAT;

	typedef logic [2:0][UNIT_W-1:0] uvec_t;

endpackage

// ===== hdl/bppl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppl_ctrl
// Valid bits of every pipeline stage and the per-stage load enables; a stage
// loads whenever it is empty or the stage after it moves.
// ----------------------------------------------------------------------------
module bppl_ctrl #(
	parameter int DEPTH = bppl_pkg::PIPE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [DEPTH-1:0] en
);
	import bppl_pkg::*;

	logic [DEPTH-1:0] valid_q;

	for (genvar k = 0; k < DEPTH; k++) begin : g_en
		if (k == DEPTH - 1) begin : g_last
			assign en[k] = ~valid_q[k] | out_ready;
		end else begin : g_mid
			assign en[k] = ~valid_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (valid_q & ~en) | ({valid_q[DEPTH-2:0], in_valid} & en);
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_q[DEPTH-1];

	// a stage may only hold while it carries a transaction
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(~en & ~valid_q) == '0)
		else $error("stage held while empty");

	// a free output frees the whole pipeline
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled with output free");

	// transactions in flight are neither lost nor duplicated
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(valid_q) == $past($countones(valid_q))
			+ $past(int'(in_valid && in_ready)) - $past(int'(out_valid && out_ready)))
		else $error("transaction count mismatch");

endmodule

// ===== hdl/bppl_dly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppl_dly
// Stall-aware delay line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module bppl_dly #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic [DEPTH-1:0] en,
	input  logic [W-1:0]     din,
	output logic [W-1:0]     dout
);
	import bppl_pkg::*;

	logic [W-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			tap_s[0] <= din;
		end
		for (int k = 1; k < DEPTH; k++) begin
			if (en[k]) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

// ===== hdl/bppl_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppl_norm
// Pipelined vector normalizer: prescale, sum of squares, one root bit and one
// quotient bit per stage, rounded Q1.14 result; a zero vector gives zero.
// ----------------------------------------------------------------------------
module bppl_norm #(
	parameter int IN_W = 17
) (
	input  logic                              clk,
	input  logic [bppl_pkg::NORM_LAT-1:0]     en,
	input  logic [2:0][IN_W-1:0]              vec,
	output bppl_pkg::uvec_t                   uvec
);
	import bppl_pkg::*;

	localparam int ST_ABS  = 0;
	localparam int ST_LZ   = 1;
	localparam int ST_SH   = 2;
	localparam int ST_SQ   = 3;
	localparam int ST_SUM  = 4;
	localparam int ST_ROOT = 5;
	localparam int ST_PREP = ST_ROOT + ROOT_W;
	localparam int ST_FIN  = ST_PREP + 1 + QUO_W;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  zero;
	} side_t;

	typedef struct packed {
		logic [2:0][NUM_W-1:0] rem;
		logic [2:0][QUO_W-1:0] quo;
		logic [MAG_W-1:0]      len;
		logic [2:0]            neg;
		logic                  zero;
	} div_t;

	side_t                   abs_s1, lz_s2, sh_s3, sq_side_s4, sum_side_s5;
	logic [SH_W-1:0]         sh_s2;
	logic [2:0][LEN2_W-1:0]  sq_s4;
	logic [LEN2_W-1:0]       len2_s5;
	logic [LEN2_W-1:0]       rx_s [ROOT_W];
	logic [LEN2_W-1:0]       rr_s [ROOT_W];
	side_t                   rside_s [ROOT_W];
	div_t                    dv_s [QUO_W+1];
	uvec_t                   uvec_s;

	logic [MAG_W-1:0]        lz_or;
	logic [SH_W-1:0]         lz_sh;

	// magnitude and sign
	always_ff @(posedge clk) begin
		if (en[ST_ABS]) begin
			for (int i = 0; i < 3; i++) begin
				abs_s1.neg[i] <= vec[i][IN_W-1];
				abs_s1.mag[i] <= vec[i][IN_W-1] ? MAG_W'(IN_W'(~vec[i] + 1'b1))
					: MAG_W'(vec[i]);
			end
			abs_s1.zero <= 1'b0;
		end
	end

	// shift needed to lift the largest magnitude to the target bit
	always_comb begin
		lz_or = abs_s1.mag[0] | abs_s1.mag[1] | abs_s1.mag[2];
		lz_sh = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (lz_or[i]) begin
				lz_sh = (i >= NORM_BIT) ? '0 : SH_W'(NORM_BIT - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_LZ]) begin
			lz_s2.mag  <= abs_s1.mag;
			lz_s2.neg  <= abs_s1.neg;
			lz_s2.zero <= (lz_or == '0);
			sh_s2      <= lz_sh;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_SH]) begin
			for (int i = 0; i < 3; i++) begin
				sh_s3.mag[i] <= lz_s2.mag[i] << sh_s2;
			end
			sh_s3.neg  <= lz_s2.neg;
			sh_s3.zero <= lz_s2.zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_SQ]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= LEN2_W'(sh_s3.mag[i]) * LEN2_W'(sh_s3.mag[i]);
			end
			sq_side_s4 <= sh_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_SUM]) begin
			len2_s5     <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			sum_side_s5 <= sq_side_s4;
		end
	end

	// integer square root, one result bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		localparam logic [LEN2_W-1:0] RBIT = LEN2_W'(1) << (2 * (ROOT_W - 1 - k));
		logic [LEN2_W-1:0] x_in, r_in, trial;
		side_t             s_in;

		if (k == 0) begin : g_first
			assign x_in = len2_s5;
			assign r_in = '0;
			assign s_in = sum_side_s5;
		end else begin : g_next
			assign x_in = rx_s[k-1];
			assign r_in = rr_s[k-1];
			assign s_in = rside_s[k-1];
		end

		assign trial = r_in + RBIT;

		always_ff @(posedge clk) begin
			if (en[ST_ROOT+k]) begin
				if (x_in >= trial) begin
					rx_s[k] <= x_in - trial;
					rr_s[k] <= (r_in >> 1) + RBIT;
				end else begin
					rx_s[k] <= x_in;
					rr_s[k] <= r_in >> 1;
				end
				rside_s[k] <= s_in;
			end
		end
	end

	// numerator with half divisor added for round to nearest
	always_ff @(posedge clk) begin
		if (en[ST_PREP]) begin
			for (int i = 0; i < 3; i++) begin
				dv_s[0].rem[i] <= NUM_W'({rside_s[ROOT_W-1].mag[i], Q_FRAC'(0)})
					+ NUM_W'(rr_s[ROOT_W-1][MAG_W-1:0] >> 1);
			end
			dv_s[0].quo  <= '0;
			dv_s[0].len  <= rr_s[ROOT_W-1][MAG_W-1:0];
			dv_s[0].neg  <= rside_s[ROOT_W-1].neg;
			dv_s[0].zero <= rside_s[ROOT_W-1].zero;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 1; j <= QUO_W; j++) begin : g_div
		localparam int QB = QUO_W - j;
		logic [NUM_W-1:0] dsr;

		assign dsr = NUM_W'(dv_s[j-1].len) << QB;

		always_ff @(posedge clk) begin
			if (en[ST_PREP+j]) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_s[j-1].rem[i] >= dsr) begin
						dv_s[j].rem[i] <= dv_s[j-1].rem[i] - dsr;
						dv_s[j].quo[i] <= dv_s[j-1].quo[i] | (QUO_W'(1) << QB);
					end else begin
						dv_s[j].rem[i] <= dv_s[j-1].rem[i];
						dv_s[j].quo[i] <= dv_s[j-1].quo[i];
					end
				end
				dv_s[j].len  <= dv_s[j-1].len;
				dv_s[j].neg  <= dv_s[j-1].neg;
				dv_s[j].zero <= dv_s[j-1].zero;
			end
		end
	end

	// cap at 1.0, restore sign, force zero vectors to zero
	always_ff @(posedge clk) begin
		if (en[ST_FIN]) begin
			for (int i = 0; i < 3; i++) begin
				logic [UNIT_W-1:0] q;
				q = (dv_s[QUO_W].quo[i] >= QUO_W'(ONE_Q14)) ? UNIT_W'(ONE_Q14)
					: UNIT_W'(dv_s[QUO_W].quo[i]);
				if (dv_s[QUO_W].zero) begin
					uvec_s[i] <= '0;
				end else if (dv_s[QUO_W].neg[i]) begin
					uvec_s[i] <= ~q + 1'b1;
				end else begin
					uvec_s[i] <= q;
				end
			end
		end
	end

	assign uvec = uvec_s;

endmodule

// ===== hdl/bppl_light.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppl_light
// Lighting stages: N.L and N.H, the specular power by eight square and
// multiply steps, the color products and the saturating channel sum.
// ----------------------------------------------------------------------------
module bppl_light (
	input  logic                                 clk,
	input  logic [bppl_pkg::LIGHT_LAT-1:0]       en,
	input  bppl_pkg::uvec_t                      un,
	input  bppl_pkg::uvec_t                      ul,
	input  bppl_pkg::uvec_t                      uh,
	input  logic [bppl_pkg::WORD_W-1:0]          intensity,
	input  logic [bppl_pkg::WORD_W-1:0]          amb,
	input  logic [bppl_pkg::WORD_W-1:0]          kd,
	input  logic [bppl_pkg::WORD_W-1:0]          ks,
	input  logic [bppl_pkg::EXP_W-1:0]           expo,
	input  logic                                 shadow,
	output logic [bppl_pkg::CHAN_W-1:0]          red,
	output logic [bppl_pkg::CHAN_W-1:0]          green,
	output logic [bppl_pkg::CHAN_W-1:0]          blue
);
	import bppl_pkg::*;

	localparam int ST_MUL = 0;
	localparam int ST_ADD = 1;
	localparam int ST_DOT = 2;
	localparam int ST_POW = 3;
	localparam int POW_N  = 2 * EXP_W;
	localparam int ST_MIX = ST_POW + POW_N;
	localparam int ST_OUT = ST_MIX + 1;
	localparam int PR_W   = 2 * UNIT_W;
	localparam int SUM_W  = PR_W + 2;
	localparam int CP_W   = 2 * CHAN_W;
	localparam int MX_W   = IK_W + DOT_W;
	localparam int ACC_W  = CHAN_W + 4;

	typedef struct packed {
		logic [DOT_W-1:0]           r;
		logic [DOT_W-1:0]           x;
		logic [DOT_W-1:0]           ndl;
		logic [EXP_W-1:0]           e;
		logic [2:0][IK_W-1:0]       ikd;
		logic [2:0][IK_W-1:0]       iks;
		logic [2:0][CHAN_W-1:0]     amb;
		logic                       lit;
	} pw_t;

	logic signed [PR_W-1:0]   pnl_s1 [3];
	logic signed [PR_W-1:0]   pnh_s1 [3];
	logic [2:0][CP_W-1:0]     ikd_s1, iks_s1;
	logic [2:0][CHAN_W-1:0]   amb_s1, amb_s2;
	logic [EXP_W-1:0]         e_s1, e_s2;
	logic                     lit_s1, lit_s2;
	logic signed [SUM_W-1:0]  snl_s2, snh_s2;
	logic [2:0][IK_W-1:0]     ikd_s2, iks_s2;
	pw_t                      pw_s [POW_N+1];
	logic [2:0][IK_W-1:0]     dif_s, spc_s;
	logic [2:0][CHAN_W-1:0]   mix_amb_s;
	logic                     mix_lit_s;
	logic [2:0][CHAN_W-1:0]   col_s;

	function automatic logic [DOT_W-1:0] pos_dot(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] t;
		t = (s + SUM_W'(HALF_Q14)) >>> Q_FRAC;
		if (s <= 0) begin
			return '0;
		end else if (t > SUM_W'(ONE_Q14)) begin
			return DOT_W'(ONE_Q14);
		end else begin
			return t[DOT_W-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			for (int i = 0; i < 3; i++) begin
				pnl_s1[i] <= $signed(un[i]) * $signed(ul[i]);
				pnh_s1[i] <= $signed(un[i]) * $signed(uh[i]);
				ikd_s1[i] <= intensity[CHAN_W*i +: CHAN_W] * kd[CHAN_W*i +: CHAN_W];
				iks_s1[i] <= intensity[CHAN_W*i +: CHAN_W] * ks[CHAN_W*i +: CHAN_W];
				amb_s1[i] <= amb[CHAN_W*i +: CHAN_W];
			end
			e_s1   <= expo;
			lit_s1 <= ~shadow;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_ADD]) begin
			logic [CP_W:0] rd, rs;
			snl_s2 <= SUM_W'(pnl_s1[0]) + SUM_W'(pnl_s1[1]) + SUM_W'(pnl_s1[2]);
			snh_s2 <= SUM_W'(pnh_s1[0]) + SUM_W'(pnh_s1[1]) + SUM_W'(pnh_s1[2]);
			for (int i = 0; i < 3; i++) begin
				rd = (CP_W+1)'(ikd_s1[i]) + (CP_W+1)'(HALF_Q14);
				rs = (CP_W+1)'(iks_s1[i]) + (CP_W+1)'(HALF_Q14);
				ikd_s2[i] <= rd[Q_FRAC +: IK_W];
				iks_s2[i] <= rs[Q_FRAC +: IK_W];
			end
			amb_s2 <= amb_s1;
			e_s2   <= e_s1;
			lit_s2 <= lit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_DOT]) begin
			pw_s[0].r   <= DOT_W'(ONE_Q14);
			pw_s[0].x   <= pos_dot(snh_s2);
			pw_s[0].ndl <= pos_dot(snl_s2);
			pw_s[0].e   <= e_s2;
			pw_s[0].ikd <= ikd_s2;
			pw_s[0].iks <= iks_s2;
			pw_s[0].amb <= amb_s2;
			pw_s[0].lit <= lit_s2;
		end
	end

	// exponent walked from the top bit: square, then multiply by base if set
	for (genvar k = 0; k < POW_N; k++) begin : g_pow
		localparam int  EB  = EXP_W - 1 - k / 2;
		localparam bit  SQR = (k % 2) == 0;
		logic [2*DOT_W:0] prod;
		logic             take;
		pw_t              nxt;

		assign take = SQR ? 1'b1 : pw_s[k].e[EB];
		assign prod = (2*DOT_W+1)'(pw_s[k].r) * (2*DOT_W+1)'(SQR ? pw_s[k].r : pw_s[k].x)
			+ (2*DOT_W+1)'(HALF_Q14);

		always_comb begin
			nxt = pw_s[k];
			if (take) begin
				nxt.r = prod[Q_FRAC +: DOT_W];
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_POW+k]) begin
				pw_s[k+1] <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_MIX]) begin
			logic [MX_W-1:0] pd, ps;
			for (int i = 0; i < 3; i++) begin
				pd = MX_W'(pw_s[POW_N].ikd[i]) * MX_W'(pw_s[POW_N].ndl) + MX_W'(HALF_Q14);
				ps = MX_W'(pw_s[POW_N].iks[i]) * MX_W'(pw_s[POW_N].r) + MX_W'(HALF_Q14);
				dif_s[i] <= pd[Q_FRAC +: IK_W];
				spc_s[i] <= ps[Q_FRAC +: IK_W];
			end
			mix_amb_s <= pw_s[POW_N].amb;
			mix_lit_s <= pw_s[POW_N].lit;
		end
	end

	// saturate each channel at full scale
	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			logic [ACC_W-1:0] acc;
			for (int i = 0; i < 3; i++) begin
				acc = ACC_W'(mix_amb_s[i]);
				if (mix_lit_s) begin
					acc = acc + ACC_W'(dif_s[i]) + ACC_W'(spc_s[i]);
				end
				col_s[i] <= (acc > ACC_W'({CHAN_W{1'b1}})) ? {CHAN_W{1'b1}}
					: acc[CHAN_W-1:0];
			end
		end
	end

	assign red   = col_s[0];
	assign green = col_s[1];
	assign blue  = col_s[2];

endmodule

// ===== hdl/blinn_phong_point_light_shader_unit.sv =====
// The result delay is set mostly by the per-bit root and quotient stages of the two
// normalizers in series, each 44 deep. Throughput: one transaction per cycle while
// out_ready is high; no state is carried between transactions.
// Stalls hold only full stages, so empty slots fill while a result waits.
// Reset clears the stage valid bits only; no memory is cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blinn_phong_point_light_shader_unit
// Shades one surface point under one point light with the Blinn-Phong model:
// normalizes N, L and E, forms H, then ambient plus diffuse and specular.
// ----------------------------------------------------------------------------
module blinn_phong_point_light_shader_unit #(
	parameter int COMPONENT_BITS = bppl_pkg::COMPONENT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bppl_pkg::WORD_W-1:0]      surface_point,
	input  logic [bppl_pkg::WORD_W-1:0]      eye_position,
	input  logic [bppl_pkg::WORD_W-1:0]      surface_normal,
	input  logic [bppl_pkg::WORD_W-1:0]      light_position,
	input  logic [bppl_pkg::WORD_W-1:0]      light_intensity,
	input  logic [bppl_pkg::WORD_W-1:0]      ambient_coeff,
	input  logic [bppl_pkg::WORD_W-1:0]      diffuse_coeff,
	input  logic [bppl_pkg::WORD_W-1:0]      specular_coeff,
	input  logic [bppl_pkg::EXP_W-1:0]       specular_exponent,
	input  logic                             in_shadow,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bppl_pkg::CHAN_W-1:0]      red,
	output logic [bppl_pkg::CHAN_W-1:0]      green,
	output logic [bppl_pkg::CHAN_W-1:0]      blue
);
	import bppl_pkg::*;

	localparam int CB     = COMPONENT_BITS;
	localparam int VW     = CB + 1;
	localparam int PACK_W = 3 * CB;
	localparam int HS_W   = UNIT_W + 1;
	localparam int MAT_W  = 1 + EXP_W + 4 * WORD_W;
	localparam int UU_W   = 2 * $bits(uvec_t);

	logic [PIPE_DEPTH-1:0]  en;
	logic [PACK_W-1:0]      pt_x, ey_x, nm_x, lp_x;
	logic [2:0][VW-1:0]     l_s1, e_s1, n_s1;
	uvec_t                  un, ul, ue, uh, un_d, ul_d;
	logic [2:0][HS_W-1:0]   hs_s;
	logic [MAT_W-1:0]       mat_d;
	logic [UU_W-1:0]        uu_d;

	bppl_ctrl #(.DEPTH(PIPE_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.en        (en)
	);

	assign pt_x = PACK_W'(surface_point);
	assign ey_x = PACK_W'(eye_position);
	assign nm_x = PACK_W'(surface_normal);
	assign lp_x = PACK_W'(light_position);

	// light and eye directions relative to the point
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				l_s1[i] <= {lp_x[CB*i+CB-1], lp_x[CB*i +: CB]}
					- {pt_x[CB*i+CB-1], pt_x[CB*i +: CB]};
				e_s1[i] <= {ey_x[CB*i+CB-1], ey_x[CB*i +: CB]}
					- {pt_x[CB*i+CB-1], pt_x[CB*i +: CB]};
				n_s1[i] <= {nm_x[CB*i+CB-1], nm_x[CB*i +: CB]};
			end
		end
	end

	bppl_norm #(.IN_W(VW)) u_norm_n (
		.clk  (clk),
		.en   (en[STG_LE +: NORM_LAT]),
		.vec  (n_s1),
		.uvec (un)
	);

	bppl_norm #(.IN_W(VW)) u_norm_l (
		.clk  (clk),
		.en   (en[STG_LE +: NORM_LAT]),
		.vec  (l_s1),
		.uvec (ul)
	);

	bppl_norm #(.IN_W(VW)) u_norm_e (
		.clk  (clk),
		.en   (en[STG_LE +: NORM_LAT]),
		.vec  (e_s1),
		.uvec (ue)
	);

	// unnormalized half vector
	always_ff @(posedge clk) begin
		if (en[STG_HS]) begin
			for (int i = 0; i < 3; i++) begin
				hs_s[i] <= {ue[i][UNIT_W-1], ue[i]} + {ul[i][UNIT_W-1], ul[i]};
			end
		end
	end

	bppl_norm #(.IN_W(HS_W)) u_norm_h (
		.clk  (clk),
		.en   (en[STG_H +: NORM_LAT]),
		.vec  (hs_s),
		.uvec (uh)
	);

	bppl_dly #(.W(UU_W), .DEPTH(STG_LIGHT - STG_HS)) u_dly_uvec (
		.clk  (clk),
		.en   (en[STG_HS +: (STG_LIGHT - STG_HS)]),
		.din  ({un, ul}),
		.dout (uu_d)
	);

	assign {un_d, ul_d} = uu_d;

	bppl_dly #(.W(MAT_W), .DEPTH(STG_LIGHT)) u_dly_mat (
		.clk  (clk),
		.en   (en[0 +: STG_LIGHT]),
		.din  ({in_shadow, specular_exponent, specular_coeff, diffuse_coeff,
			ambient_coeff, light_intensity}),
		.dout (mat_d)
	);

	bppl_light u_light (
		.clk       (clk),
		.en        (en[STG_LIGHT +: LIGHT_LAT]),
		.un        (un_d),
		.ul        (ul_d),
		.uh        (uh),
		.intensity (mat_d[0 +: WORD_W]),
		.amb       (mat_d[WORD_W +: WORD_W]),
		.kd        (mat_d[2*WORD_W +: WORD_W]),
		.ks        (mat_d[3*WORD_W +: WORD_W]),
		.expo      (mat_d[4*WORD_W +: EXP_W]),
		.shadow    (mat_d[MAT_W-1]),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blinn-Phong point-light shader testbench
// Drives shading transactions with random gaps, predicts each color with a
// bit-exact fixed-point model and compares the returned channels in order.
// ----------------------------------------------------------------------------
module testbench;
	import bppl_pkg::*;

	localparam int CB = COMPONENT_BITS_DEF;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [WORD_W-1:0] pt, eye, nrm, lpos, inten, amb, dif, spc;
		logic [EXP_W-1:0]  expo;
		logic              shadow;
	} shade_req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] r, g, b;
	} color_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	logic in_ready, out_valid;
	shade_req_t req = '0;
	logic [CHAN_W-1:0] red, green, blue;

	color_t color_queue[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	bit hold_off = 0;
	bit gaps_on = 1;

	always #1 clk = ~clk;

	blinn_phong_point_light_shader_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.surface_point(req.pt), .eye_position(req.eye),
		.surface_normal(req.nrm), .light_position(req.lpos),
		.light_intensity(req.inten), .ambient_coeff(req.amb),
		.diffuse_coeff(req.dif), .specular_coeff(req.spc),
		.specular_exponent(req.expo), .in_shadow(req.shadow),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue)
	);

	function automatic longint comp_val(logic [WORD_W-1:0] w, int k);
		logic [CB-1:0] c;
		c = w[k*CB +: CB];
		return longint'($signed(c));
	endfunction

	function automatic longint unsigned sqrt_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void normalize(input longint v[3], output longint u[3]);
		longint unsigned m[3], big, len2, len, q;
		bit neg[3];
		big = 0;
		len2 = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			m[i] = neg[i] ? -v[i] : v[i];
			if (m[i] > big) big = m[i];
		end
		if (big == 0) begin
			u = '{0, 0, 0};
			return;
		end
		while (big < (64'd1 << NORM_BIT)) begin
			big <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) len2 += m[i] * m[i];
		len = sqrt_floor(len2);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << Q_FRAC) + len / 2) / len;
			if (q > ONE_Q14) q = ONE_Q14;
			u[i] = neg[i] ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic longint unsigned clamped_dot(longint a[3], longint b[3]);
		longint s;
		longint unsigned d;
		s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		if (s <= 0) return 0;
		d = (unsigned'(s) + HALF_Q14) >> Q_FRAC;
		return d > ONE_Q14 ? ONE_Q14 : d;
	endfunction

	function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
		return (a * b + HALF_Q14) >> Q_FRAC;
	endfunction

	function automatic color_t shade(shade_req_t t);
		longint p[3], e[3], n[3], l[3], un[3], ul[3], ue[3], hs[3], uh[3];
		longint unsigned ndl, ndh, pw, c, li;
		longint unsigned ch[3];
		color_t res;
		for (int i = 0; i < 3; i++) begin
			p[i] = comp_val(t.pt, i);
			e[i] = comp_val(t.eye, i) - p[i];
			n[i] = comp_val(t.nrm, i);
			l[i] = comp_val(t.lpos, i) - p[i];
		end
		normalize(n, un);
		normalize(l, ul);
		normalize(e, ue);
		for (int i = 0; i < 3; i++) hs[i] = ue[i] + ul[i];
		normalize(hs, uh);
		ndl = clamped_dot(un, ul);
		ndh = clamped_dot(un, uh);
		pw = ONE_Q14;
		for (int b = EXP_W - 1; b >= 0; b--) begin
			pw = qmul(pw, pw);
			if (t.expo[b]) pw = qmul(pw, ndh);
		end
		for (int i = 0; i < 3; i++) begin
			c = t.amb[16*i +: 16];
			if (!t.shadow) begin
				li = t.inten[16*i +: 16];
				c += qmul(qmul(li, t.dif[16*i +: 16]), ndl);
				c += qmul(qmul(li, t.spc[16*i +: 16]), pw);
			end
			ch[i] = c > 16'hFFFF ? 16'hFFFF : c;
		end
		res.r = CHAN_W'(ch[0]);
		res.g = CHAN_W'(ch[1]);
		res.b = CHAN_W'(ch[2]);
		return res;
	endfunction

	// Hold valid until accepted; keep it high into the next transaction if no gap.
	task automatic send_shade(shade_req_t t);
		int gap;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req <= t;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		color_queue.push_back(shade(t));
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		return WORD_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [WORD_W-1:0] pack_vec(int x, int y, int z);
		return {CB'(z), CB'(y), CB'(x)};
	endfunction

	function automatic shade_req_t rand_req();
		shade_req_t t;
		t.pt = rand_word();
		t.eye = rand_word();
		t.nrm = rand_word();
		t.lpos = rand_word();
		t.inten = rand_word();
		t.amb = rand_word();
		t.dif = rand_word();
		t.spc = rand_word();
		t.expo = EXP_W'($urandom());
		t.shadow = 1'($urandom_range(0, 1));
		return t;
	endfunction

	// Plausible scene: small vectors, light above, modest colors.
	function automatic shade_req_t scene_req();
		shade_req_t t;
		t = rand_req();
		t.pt = pack_vec($urandom_range(0, 1024) - 512, $urandom_range(0, 1024) - 512, 0);
		t.nrm = pack_vec($urandom_range(0, 512) - 256, $urandom_range(0, 512) - 256,
			$urandom_range(1, 1024));
		t.lpos = pack_vec($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
			$urandom_range(256, 8000));
		t.eye = pack_vec($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
			$urandom_range(256, 8000));
		for (int i = 0; i < 3; i++) begin
			t.inten[16*i +: 16] = CHAN_W'($urandom_range(0, 16384));
			t.amb[16*i +: 16] = CHAN_W'($urandom_range(0, 4096));
			t.dif[16*i +: 16] = CHAN_W'($urandom_range(0, 16384));
			t.spc[16*i +: 16] = CHAN_W'($urandom_range(0, 16384));
		end
		t.shadow = ($urandom_range(0, 3) == 0);
		t.expo = EXP_W'(($urandom_range(0, 1)) ? $urandom_range(0, 64) : $urandom());
		return t;
	endfunction

	task automatic test_directed();
		shade_req_t t;
		t = scene_req();
		t.shadow = 0;
		send_shade(t);
		t.shadow = 1;
		send_shade(t);
		// zero normal: no diffuse term, and no specular term unless the exponent is zero
		t.shadow = 0;
		t.nrm = '0;
		send_shade(t);
		// eye and light opposite: half vector zero
		t = scene_req();
		t.shadow = 0;
		t.pt = '0;
		t.lpos = pack_vec(0, 0, 256);
		t.eye = pack_vec(0, 0, -256);
		t.nrm = pack_vec(0, 0, 256);
		t.expo = '0;
		send_shade(t);
		t.expo = 8'hFF;
		send_shade(t);
		// light at the point itself
		t.lpos = t.pt;
		send_shade(t);
		// aligned vectors, all coefficients at full scale: saturation
		t.pt = '0;
		t.lpos = pack_vec(0, 0, 32767);
		t.eye = pack_vec(0, 0, 32767);
		t.nrm = pack_vec(0, 0, 1);
		t.inten = '1;
		t.amb = '1;
		t.dif = '1;
		t.spc = '1;
		t.expo = 8'd1;
		send_shade(t);
		// extreme components
		t.pt = pack_vec(-32768, -32768, -32768);
		t.lpos = pack_vec(32767, 32767, 32767);
		t.eye = pack_vec(32767, -32768, 32767);
		t.nrm = pack_vec(-32768, 32767, 0);
		t.amb = '0;
		send_shade(t);
		t.inten = '0;
		t.dif = '0;
		t.spc = '0;
		t.expo = '0;
		send_shade(t);
		t = '1;
		send_shade(t);
		t = '0;
		send_shade(t);
		for (int k = 0; k < 8; k++) begin
			t = scene_req();
			t.expo = 8'd1 << k;
			t.shadow = 0;
			send_shade(t);
		end
	endtask

	task automatic test_random();
		for (int k = 0; k < 480; k++)
			send_shade(($urandom_range(0, 4) == 0) ? rand_req() : scene_req());
	endtask

	// Hold the receiver off long enough to fill the pipeline.
	task automatic test_backpressure();
		hold_off = 1;
		gaps_on = 0;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
		join_none
		for (int k = 0; k < 200; k++) send_shade(scene_req());
		gaps_on = 1;
	endtask

	// Receiver: random stall per transaction, check against oldest prediction.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			while (hold_off) begin
				out_ready <= 0;
				@(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (color_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result r=%h g=%h b=%h", red, green, blue);
			end else begin
				color_t exp_c;
				exp_c = color_queue.pop_front();
				if (exp_c.r !== red || exp_c.g !== green || exp_c.b !== blue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %h, got %h %h %h",
							exp_c.r, exp_c.g, exp_c.b, red, green, blue);
				end
			end
		end
	end

	// Watchdog: cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		in_valid <= 0;
		while (color_queue.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
